[rtl/ffha_pkg.sv]
package ffha_pkg;

  // Heap geometry
  localparam int HEAP_BYTES    = 1024;
  localparam int GRANULE_BYTES = 8;
  localparam int NUM_GRANULES  = HEAP_BYTES / GRANULE_BYTES;
  localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);
  localparam int GRAN_AW       = $clog2(NUM_GRANULES);
  localparam int CNT_W         = GRAN_AW + 1;
  localparam int HDR_W         = CNT_W + 1;

  // Field widths
  localparam int REQ_W    = 10;
  localparam int OFF_W    = 10;
  localparam int BYTES_W  = 11;
  localparam int STATUS_W = 3;

  // Actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXTENDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OOM      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

  typedef struct packed {
    logic               action;
    logic [REQ_W-1:0]   request_size;
    logic [OFF_W-1:0]   payload_offset;
  } ffha_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    granted_offset;
    logic [BYTES_W-1:0]  granted_bytes;
  } ffha_out_t;

endpackage

[rtl/ffha_ram.sv]
module ffha_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/first_fit_heap_allocator_core.sv]
// Free reads the block header and writes it back marked free; an invalid free is ignored.
// Allocate walks the block headers for a free block to reuse, else extends at the top mark.
// Throughput: one item at a time; the header walk reads one header per cycle.
// A result waiting at the output does not block taking the next item, but holds it in S_OUT.
// Reset (rst_n low, synchronous): top mark cleared to zero, control idle, no result
// pending. The header store is not cleared.
module first_fit_heap_allocator_core import ffha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ffha_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ffha_out_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_EXT  = 3'd2;
  localparam logic [2:0] S_FREE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    top_r, top_nxt;
  logic [CNT_W-1:0]    g_r, g_nxt;
  logic [CNT_W-1:0]    need_r, need_nxt;
  logic [GRAN_AW-1:0]  fg_r, fg_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [GRAN_AW-1:0]  res_gran_r, res_gran_nxt;
  logic [CNT_W-1:0]    res_size_r, res_size_nxt;
  logic                out_valid_r, out_valid_nxt;
  ffha_out_t           out_data_r, out_data_nxt;

  logic                ram_we;
  logic [GRAN_AW-1:0]  ram_waddr;
  logic [HDR_W-1:0]    ram_wdata;
  logic [GRAN_AW-1:0]  ram_raddr;
  logic [HDR_W-1:0]    ram_rdata;

  logic [REQ_W:0]      req_sum;
  logic [CNT_W-1:0]    in_need;
  logic [GRAN_AW-1:0]  off_gran;
  logic [GRAN_AW-1:0]  free_gran;
  logic                free_skip;
  logic [CNT_W-1:0]    hdr_size;
  logic [CNT_W:0]      walk_next;
  logic [CNT_W:0]      top_sum;
  logic [CNT_W-1:0]    gran_plus;
  logic [BYTES_W-1:0]  off_full;
  logic                out_free;

  ffha_ram #(.WIDTH(HDR_W), .DEPTH(NUM_GRANULES)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode incoming request
  assign req_sum   = (REQ_W+1)'(in_data.request_size) + (REQ_W+1)'(2*GRANULE_BYTES - 1);
  assign in_need   = CNT_W'(req_sum >> GRAN_SHIFT);
  assign off_gran  = in_data.payload_offset[OFF_W-1:GRAN_SHIFT];
  assign free_gran = off_gran - GRAN_AW'(1);
  assign free_skip = (in_data.payload_offset == '0)
                  || (in_data.payload_offset[GRAN_SHIFT-1:0] != '0)
                  || ({1'b0, free_gran} >= top_r);

  // Walk arithmetic on the header just read
  assign hdr_size  = ram_rdata[HDR_W-1:1];
  assign walk_next = {1'b0, g_r} + {1'b0, hdr_size};
  assign top_sum   = {1'b0, top_r} + {1'b0, need_r};

  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // Result formatting
  assign gran_plus = {1'b0, res_gran_r} + CNT_W'(1);
  assign off_full  = BYTES_W'({gran_plus, {GRAN_SHIFT{1'b0}}});

  // Sequencer: walk, extend, free and hand off
  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    g_nxt          = g_r;
    need_nxt       = need_r;
    fg_nxt         = fg_r;
    res_status_nxt = res_status_r;
    res_gran_nxt   = res_gran_r;
    res_size_nxt   = res_size_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = fg_r;
    ram_wdata      = '0;
    ram_raddr      = '0;

    // drop the output item once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.action == ACT_ALLOC) begin
            need_nxt  = in_need;
            g_nxt     = '0;
            ram_raddr = '0;
            state_nxt = (top_r == '0) ? S_EXT : S_WALK;
          end else if (free_skip) begin
            res_status_nxt = ST_IGNORED;
            state_nxt      = S_OUT;
          end else begin
            fg_nxt    = free_gran;
            ram_raddr = free_gran;
            state_nxt = S_FREE;
          end
        end
      end
      S_WALK: begin
        if (hdr_size == '0) begin
          state_nxt = S_EXT;
        end else if (!ram_rdata[0] && hdr_size >= need_r) begin
          ram_we         = 1'b1;
          ram_waddr      = g_r[GRAN_AW-1:0];
          ram_wdata      = ram_rdata | HDR_W'(1);
          res_status_nxt = ST_REUSED;
          res_gran_nxt   = g_r[GRAN_AW-1:0];
          res_size_nxt   = hdr_size;
          state_nxt      = S_OUT;
        end else begin
          g_nxt     = walk_next[CNT_W-1:0];
          ram_raddr = walk_next[GRAN_AW-1:0];
          if (walk_next >= {1'b0, top_r}) begin
            state_nxt = S_EXT;
          end
        end
      end
      S_EXT: begin
        if (top_sum > (CNT_W+1)'(NUM_GRANULES)) begin
          res_status_nxt = ST_OOM;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = top_r[GRAN_AW-1:0];
          ram_wdata      = {need_r, 1'b1};
          top_nxt        = top_sum[CNT_W-1:0];
          res_status_nxt = ST_EXTENDED;
          res_gran_nxt   = top_r[GRAN_AW-1:0];
          res_size_nxt   = need_r;
        end
        state_nxt = S_OUT;
      end
      S_FREE: begin
        ram_we         = 1'b1;
        ram_waddr      = fg_r;
        ram_wdata      = {hdr_size, 1'b0};
        res_status_nxt = ST_FREED;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.status  = res_status_r;
          if (res_status_r == ST_REUSED || res_status_r == ST_EXTENDED) begin
            out_data_nxt.granted_offset = off_full[OFF_W-1:0];
            out_data_nxt.granted_bytes  = BYTES_W'({res_size_r, {GRAN_SHIFT{1'b0}}});
          end else begin
            out_data_nxt.granted_offset = '0;
            out_data_nxt.granted_bytes  = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    g_r          <= g_nxt;
    need_r       <= need_nxt;
    fg_r         <= fg_nxt;
    res_status_r <= res_status_nxt;
    res_gran_r   <= res_gran_nxt;
    res_size_r   <= res_size_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/ffha_checker.sv]
module ffha_checker import ffha_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input ffha_out_t out_data
);

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  // Busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while first still in work");

  // Only defined status codes leave the block
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_REUSED || out_data.status == ST_EXTENDED
                || out_data.status == ST_OOM || out_data.status == ST_FREED
                || out_data.status == ST_IGNORED))
    else $error("undefined status code");

  // No grant fields without a grant
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_OOM || out_data.status == ST_FREED
               || out_data.status == ST_IGNORED)
    |-> out_data.granted_offset == '0 && out_data.granted_bytes == '0)
    else $error("grant fields set on a non-grant item");

  // A granted block has a whole, nonzero number of granules and a granule-aligned offset
  a_grant_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_REUSED || out_data.status == ST_EXTENDED)
    |-> out_data.granted_bytes != '0
     && out_data.granted_bytes[GRAN_SHIFT-1:0] == '0
     && out_data.granted_offset[GRAN_SHIFT-1:0] == '0)
    else $error("granted block not granule aligned");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (.*);
